@@ design/ipv4v_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the IPv4 address string validator.
// No dependencies; every design file but the interfaces uses this package.
package ipv4v_pkg;

    localparam int LEN_W = 5;
    localparam int DOT_W = 2;
    localparam int DIG_W = 2;
    localparam int OCT_W = 10;

    localparam logic [LEN_W-1:0] LEN_MIN = 5'd7;
    localparam logic [LEN_W-1:0] LEN_MAX = 5'd15;
    localparam logic [LEN_W-1:0] LEN_SAT = 5'd31;
    localparam logic [DOT_W-1:0] MAX_DOTS = 2'd3;
    localparam logic [DIG_W-1:0] MAX_DIGITS = 2'd3;
    localparam logic [OCT_W-1:0] ADDR_LIMIT = 10'd254;
    localparam logic [OCT_W-1:0] MASK_LIMIT = 10'd255;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_UX = 8'h58;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    // default depth of the queue between the classifier and the checker
    localparam int Q_DEPTH = 2;

    // one classified character
    typedef struct packed {
        logic       is_digit;
        logic       is_dot;
        logic       is_x;
        logic       is_hexd;
        logic       is_zero;
        logic [3:0] digit;
        logic       last;
    } char_class_t;

endpackage

@@ design/ipv4v_if.sv @@
`timescale 1ns / 1ps
// Handshake channels of the validator: character input, result output and
// the mode register write port. Depends on nothing.
interface ipv4v_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface ipv4v_res_if;
    logic valid;
    logic ready;
    logic valid_res;
    logic hex_form;
    modport source (output valid, output valid_res, output hex_form, input ready);
    modport sink (input valid, input valid_res, input hex_form, output ready);
endinterface

interface ipv4v_cfg_if;
    logic valid;
    logic ready;
    logic netmask_mode;
    modport source (output valid, output netmask_mode, input ready);
    modport sink (input valid, input netmask_mode, output ready);
endinterface

@@ design/ipv4v_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts characters and classifies them for the queue.
// Depends on ipv4v_pkg and ipv4v_char_if.
module ipv4v_front (
    ipv4v_char_if.sink             char_in,
    output ipv4v_pkg::char_class_t push_data,
    output logic                   push_valid,
    input  logic                   push_ready
);
    import ipv4v_pkg::*;

    logic [7:0] c;
    logic [3:0] off;

    assign c   = char_in.char_code;
    assign off = c[3:0] - CH_ZERO[3:0];

    always_comb
    begin
        push_data.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        push_data.is_dot   = (c == CH_DOT);
        push_data.is_x     = (c == CH_LX) || (c == CH_UX);
        push_data.is_hexd  = push_data.is_digit || ((c >= CH_LA) && (c <= CH_LF))
                             || ((c >= CH_UA) && (c <= CH_UF));
        push_data.is_zero  = (c == CH_ZERO);
        push_data.digit    = off;
        push_data.last     = char_in.last_char;
    end

    assign push_valid   = char_in.valid;
    assign char_in.ready = push_ready;

endmodule

@@ design/ipv4v_queue.sv @@
`timescale 1ns / 1ps
// Small FIFO that decouples the classifier from the string checker.
// Depends on ipv4v_pkg.
module ipv4v_queue #(
    parameter int QDEPTH = ipv4v_pkg::Q_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipv4v_pkg::char_class_t push_data,
    input  logic                   push_valid,
    output logic                   push_ready,
    output ipv4v_pkg::char_class_t pop_data,
    output logic                   pop_valid,
    input  logic                   pop_ready
);
    import ipv4v_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    char_class_t    mem_reg [QDEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/ipv4v_back.sv @@
`timescale 1ns / 1ps
// Back end: runs the dotted and hex checks per character, holds the mode
// register and the result register. Depends on ipv4v_pkg and the interfaces.
module ipv4v_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipv4v_pkg::char_class_t pop_data,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    ipv4v_res_if.source            res_out,
    ipv4v_cfg_if.sink              cfg
);
    import ipv4v_pkg::*;

    logic              mode_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [DOT_W-1:0]  dots_reg, dots_next;
    logic [DIG_W-1:0]  digs_reg, digs_next;
    logic [OCT_W-1:0]  oct_reg, oct_next;
    logic              prev_dot_reg, prev_dot_next;
    logic              first_zero_reg, first_zero_next;
    logic              dot_fail_reg, dot_fail_next;
    logic              hex_fail_reg, hex_fail_next;
    logic              saw_x_reg, saw_x_next;
    logic              rv_reg, rv_next;
    logic              res_ok_reg, res_ok_next;
    logic              res_hex_reg, res_hex_next;

    logic              take;
    logic [OCT_W-1:0]  limit;
    logic [OCT_W-1:0]  oct_shift;
    logic              len_ok, dot_ok;

    assign cfg.ready   = 1'b1;
    assign limit       = mode_reg ? MASK_LIMIT : ADDR_LIMIT;
    // octet * 10 + digit, kept to the register width
    assign oct_shift   = {oct_reg[OCT_W-4:0], 3'b000} + {oct_reg[OCT_W-2:0], 1'b0}
                         + {{(OCT_W-4){1'b0}}, pop_data.digit};
    // a character with no result never waits on the output register
    assign pop_ready   = !rv_reg || res_out.ready || !pop_data.last;
    assign take        = pop_valid && pop_ready;

    assign res_out.valid     = rv_reg;
    assign res_out.valid_res = res_ok_reg;
    assign res_out.hex_form  = res_hex_reg;

    always_comb
    begin
        len_next        = len_reg;
        dots_next       = dots_reg;
        digs_next       = digs_reg;
        oct_next        = oct_reg;
        prev_dot_next   = prev_dot_reg;
        first_zero_next = first_zero_reg;
        dot_fail_next   = dot_fail_reg;
        hex_fail_next   = hex_fail_reg;
        saw_x_next      = saw_x_reg;
        rv_next         = rv_reg && !res_out.ready;
        res_ok_next     = res_ok_reg;
        res_hex_next    = res_hex_reg;
        len_ok          = 1'b0;
        dot_ok          = 1'b0;

        if (take)
        begin
            len_next   = (len_reg == LEN_SAT) ? len_reg : len_reg + 1'b1;
            saw_x_next = saw_x_reg || pop_data.is_x;

            // hex form: x only as the second char after a leading zero
            if ((len_reg == LEN_W'(1)) && pop_data.is_x)
            begin
                hex_fail_next = hex_fail_reg || !first_zero_reg;
            end
            else
            begin
                hex_fail_next = hex_fail_reg || !pop_data.is_hexd;
            end
            if (len_reg == '0)
            begin
                first_zero_next = pop_data.is_zero;
            end

            // dotted form
            priority if (pop_data.is_digit)
            begin
                if (digs_reg == MAX_DIGITS)
                begin
                    dot_fail_next = 1'b1;
                end
                else
                begin
                    digs_next = digs_reg + 1'b1;
                    oct_next  = oct_shift;
                end
                prev_dot_next = 1'b0;
            end
            else if (pop_data.is_dot)
            begin
                if ((len_reg == '0) || prev_dot_reg || (oct_reg > limit)
                    || (dots_reg == MAX_DOTS))
                begin
                    dot_fail_next = 1'b1;
                end
                if (dots_reg != MAX_DOTS)
                begin
                    dots_next = dots_reg + 1'b1;
                end
                oct_next      = '0;
                digs_next     = '0;
                prev_dot_next = 1'b1;
            end
            else
            begin
                dot_fail_next = 1'b1;
                prev_dot_next = 1'b0;
            end

            if (pop_data.last)
            begin
                len_ok = (len_next >= LEN_MIN) && (len_next <= LEN_MAX);
                dot_ok = !dot_fail_next && (dots_next == MAX_DOTS) && (digs_next != '0)
                         && (oct_next <= limit) && (mode_reg || (oct_next != '0));
                rv_next      = 1'b1;
                res_hex_next = saw_x_next;
                res_ok_next  = len_ok && (saw_x_next ? !hex_fail_next : dot_ok);

                // string done: clear for the next one
                len_next        = '0;
                dots_next       = '0;
                digs_next       = '0;
                oct_next        = '0;
                prev_dot_next   = 1'b0;
                first_zero_next = 1'b0;
                dot_fail_next   = 1'b0;
                hex_fail_next   = 1'b0;
                saw_x_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            len_reg        <= '0;
            dots_reg       <= '0;
            digs_reg       <= '0;
            oct_reg        <= '0;
            prev_dot_reg   <= 1'b0;
            first_zero_reg <= 1'b0;
            dot_fail_reg   <= 1'b0;
            hex_fail_reg   <= 1'b0;
            saw_x_reg      <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                mode_reg <= cfg.netmask_mode;
            end
            len_reg        <= len_next;
            dots_reg       <= dots_next;
            digs_reg       <= digs_next;
            oct_reg        <= oct_next;
            prev_dot_reg   <= prev_dot_next;
            first_zero_reg <= first_zero_next;
            dot_fail_reg   <= dot_fail_next;
            hex_fail_reg   <= hex_fail_next;
            saw_x_reg      <= saw_x_next;
            rv_reg         <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ok_reg  <= res_ok_next;
        res_hex_reg <= res_hex_next;
    end

endmodule

@@ design/ipv4_address_string_validator.sv @@
`timescale 1ns / 1ps
// Throughput: one character per cycle, sustained, while results are taken.
// A final character's result passes through the queue and then the result
// register before it shows.
// The queue of QDEPTH entries lets input continue while a result is stalled.
// Reset (rst_n low, asynchronous) empties the queue, drops any result, clears
// the string state and sets the mode to host address.
module ipv4_address_string_validator #(
    parameter int QDEPTH = ipv4v_pkg::Q_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    ipv4v_char_if.sink  char_in,
    ipv4v_res_if.source res_out,
    ipv4v_cfg_if.sink   cfg
);
    import ipv4v_pkg::*;

    char_class_t push_data;
    logic        push_valid, push_ready;
    char_class_t pop_data;
    logic        pop_valid, pop_ready;

    // classify each accepted character
    ipv4v_front u_front (
        .char_in    (char_in),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // hold classified characters so either side may stall on its own
    ipv4v_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // advance the string checks and emit a result on each final character
    ipv4v_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .res_out   (res_out),
        .cfg       (cfg)
    );

endmodule

@@ design/ipv4v_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the validator and the bind that attaches them.
// Depends on ipv4v_pkg and ipv4_address_string_validator.
module ipv4v_checker #(
    parameter int QDEPTH = ipv4v_pkg::Q_DEPTH
) (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_ok,
    input logic out_hex
);
    localparam int PW = $clog2(QDEPTH + 3);
    localparam logic [PW-1:0] MAX_PEND = PW'(QDEPTH + 1);

    logic [PW-1:0] pend_reg;
    logic          in_fin, out_take;

    assign in_fin   = in_valid && in_ready && in_last;
    assign out_take = out_valid && out_ready;

    // count final characters whose result is not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_fin && !out_take)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (out_take && !in_fin && (pend_reg != '0))
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != '0))
        else $error("result shown with no final character pending");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= MAX_PEND)
        else $error("more results pending than the design can hold");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_ok) && $stable(out_hex)))
        else $error("stalled result changed or dropped");

endmodule

bind ipv4_address_string_validator ipv4v_checker #(
    .QDEPTH (QDEPTH)
) u_ipv4v_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (char_in.valid),
    .in_ready  (char_in.ready),
    .in_last   (char_in.last_char),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_ok    (res_out.valid_res),
    .out_hex   (res_out.hex_form)
);
